>>> rtl/core/rgbe_rle_scanline_decoder_unit_defines.svh
// Assertion macros used by the decoder datapath.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef RGBE_RLE_SCANLINE_DECODER_UNIT_DEFINES_SVH
`define RGBE_RLE_SCANLINE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RGBE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbe assertion failed");

// Next-cycle implication.
`define RGBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbe assertion failed");

`endif

>>> rtl/core/rgbe_pkg.sv
// Shared types, constants and the mantissa-exponent to single conversion.
// Used by the controller, the datapath and the top level.
package rgbe_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = 12;
    localparam logic [7:0] MAGIC_BYTE = 8'h02;
    localparam logic [7:0] RUN_MARK   = 8'd128;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BAD_COUNT = 2'd3;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [1:0] PLANE_E = 2'd3;

    typedef enum logic [2:0] {
        PH_MAGIC1, PH_MAGIC2, PH_LENHI, PH_LENLO,
        PH_COUNT, PH_VALUE, PH_LITERAL, PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        S_BYTE, S_WRITE, S_RD0, S_RD1, S_RD2, S_EMIT, S_ERR
    } state_t;

    typedef enum logic [1:0] {
        OUT_NONE, OUT_FAIL, OUT_DEP
    } outcome_t;

    typedef struct packed {
        logic accept;
        logic wr;
        logic rd_second;
        logic cap_a;
        logic cap_b;
        logic emit;
        logic err_load;
    } cmd_t;

    typedef struct packed {
        outcome_t outcome;
        logic     dep_exp;
        logic     wr_last;
        logic     pair_last;
        logic     out_free;
    } stat_t;

    function automatic logic [31:0] to_single(input logic [7:0] m, input logic [7:0] e);
        logic [8:0]  n;
        logic [3:0]  k;
        logic [8:0]  ek;
        logic [31:0] nw;
        logic [31:0] r;
        n  = {m, 1'b1};
        k  = 4'd0;
        for (int j = 1; j < 9; j++)
        begin
            if (n[j])
            begin
                k = 4'(j);
            end
        end
        ek = {1'b0, e} + {5'd0, k};
        nw = {23'd0, n};
        r  = 32'd0;
        if (e == 8'd0)
        begin
            r = 32'd0;
        end
        else if (ek >= 9'd11)
        begin
            r[31]    = 1'b0;
            r[30:23] = 8'(ek - 9'd10);
            r[22:0]  = 23'(nw << (5'd23 - {1'b0, k}));
        end
        else
        begin
            r = nw << (e[4:0] + 5'd12);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rgbe_rle_scanline_decoder_unit.sv
// Top level of the RGBE adaptive run-length scanline decoder.
// Depends on rgbe_pkg, rgbe_ctrl and rgbe_dp.
//
// Bytes of the encoded pixel stream enter one per transfer; a byte that yields
// no result and no row-store write leaves the decoder ready for the next byte.
// A run or literal byte of the R, G or B plane then writes its pixels one at a
// time before the next byte is taken, as the row store has a single write port
// per plane. An exponent byte yields its results one pixel pair at a time, each
// through an address step, two row-store reads and the result load, and waits
// while the result register is not yet taken; an error result waits likewise.
module rgbe_rle_scanline_decoder_unit
    import rgbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] first_red,
    output logic [31:0] first_green,
    output logic [31:0] first_blue,
    output logic [31:0] second_red,
    output logic [31:0] second_green,
    output logic [31:0] second_blue,
    output logic [11:0] column,
    output logic [15:0] scanline,
    output logic [1:0]  pixel_count,
    output logic        last_of_run,
    output logic        image_done,
    output logic [1:0]  status
);

    cmd_t  cmd;
    stat_t stat;

    rgbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rgbe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_byte    (data_byte),
        .start_image  (start_image),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .column       (column),
        .scanline     (scanline),
        .pixel_count  (pixel_count),
        .last_of_run  (last_of_run),
        .image_done   (image_done),
        .status       (status)
    );

endmodule

>>> rtl/core/rgbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rgbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/rgbe_ctrl.sv
// Controller state machine of the decoder: sequences byte accept, plane
// writes, pixel reads and result loads. Depends on rgbe_pkg.
module rgbe_ctrl
    import rgbe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BYTE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_BYTE:
            begin
                if (in_valid)
                begin
                    case (stat.outcome)
                        OUT_FAIL: state_next = S_ERR;
                        OUT_DEP:  state_next = stat.dep_exp ? S_RD0 : S_WRITE;
                        default:  state_next = S_BYTE;
                    endcase
                end
            end
            S_WRITE:
            begin
                if (stat.wr_last)
                begin
                    state_next = S_BYTE;
                end
            end
            S_RD0: state_next = S_RD1;
            S_RD1: state_next = S_RD2;
            S_RD2: state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.pair_last ? S_BYTE : S_RD0;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    state_next = S_BYTE;
                end
            end
            default: state_next = S_BYTE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_BYTE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_WRITE: cmd.wr = 1'b1;
            S_RD1:
            begin
                cmd.cap_a     = 1'b1;
                cmd.rd_second = 1'b1;
            end
            S_RD2:   cmd.cap_b = 1'b1;
            S_EMIT:  cmd.emit = stat.out_free;
            S_ERR:   cmd.err_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/rgbe_dp.sv
// Datapath of the decoder: scanline parse state, row store, run registers, pixel
// conversion and the result register. Depends on rgbe_pkg, rgbe_ram and the defines file.
`include "rgbe_rle_scanline_decoder_unit_defines.svh"
module rgbe_dp
    import rgbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [7:0]  data_byte,
    input  logic        start_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] first_red,
    output logic [31:0] first_green,
    output logic [31:0] first_blue,
    output logic [31:0] second_red,
    output logic [31:0] second_green,
    output logic [31:0] second_blue,
    output logic [11:0] column,
    output logic [15:0] scanline,
    output logic [1:0]  pixel_count,
    output logic        last_of_run,
    output logic        image_done,
    output logic [1:0]  status
);

    logic [12:0] width_reg;
    logic [15:0] height_reg;
    phase_t      phase_reg, phase_next;
    logic [1:0]  plane_reg, plane_next;
    logic [12:0] pos_reg, pos_next;
    logic [7:0]  lit_reg, lit_next;
    logic [6:0]  run_reg, run_next;
    logic [7:0]  lenhi_reg, lenhi_next;
    logic [15:0] row_reg, row_next;
    logic        halt_reg, halt_next;
    logic [1:0]  err_reg, err_next;

    logic [11:0] rbase_reg;
    logic [6:0]  rcnt_reg;
    logic [7:0]  rval_reg;
    logic [1:0]  rplane_reg;
    logic        rend_reg;
    logic        rlast_reg;
    logic [15:0] rrow_reg;
    logic [6:0]  ridx_reg;
    logic [23:0] pix_a_reg;
    logic [23:0] pix_b_reg;

    logic        out_valid_reg;
    logic [31:0] o_r1_reg, o_g1_reg, o_b1_reg, o_r2_reg, o_g2_reg, o_b2_reg;
    logic [11:0] o_col_reg;
    logic [15:0] o_row_reg;
    logic [1:0]  o_cnt_reg;
    logic        o_last_reg;
    logic        o_done_reg;
    logic [1:0]  o_st_reg;

    phase_t      e_phase;
    logic [1:0]  e_plane;
    logic [12:0] e_pos;
    logic [7:0]  e_lit;
    logic [6:0]  e_run;
    logic [7:0]  e_lenhi;
    logic [15:0] e_row;
    logic        e_halt;
    logic [12:0] lim;
    logic [12:0] left;
    logic [15:0] len;
    logic [6:0]  dep_c;
    logic        dep;
    logic [13:0] dep_sum;
    logic        dep_end;
    logic        dep_lastrow;
    outcome_t    outcome;

    logic [7:0]  rem;
    logic        two;
    logic        pair_last;
    logic        out_free;
    logic        load;
    logic [11:0] waddr;
    logic [11:0] raddr;
    logic [7:0]  rd_r, rd_g, rd_b;

    always_comb
    begin
        lim = (width_reg > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_reg;
        if (start_image)
        begin
            e_phase = PH_MAGIC1;
            e_plane = 2'd0;
            e_pos   = 13'd0;
            e_lit   = 8'd0;
            e_run   = 7'd0;
            e_lenhi = 8'd0;
            e_row   = 16'd0;
            e_halt  = 1'b0;
        end
        else
        begin
            e_phase = phase_reg;
            e_plane = plane_reg;
            e_pos   = pos_reg;
            e_lit   = lit_reg;
            e_run   = run_reg;
            e_lenhi = lenhi_reg;
            e_row   = row_reg;
            e_halt  = halt_reg;
        end
        left = (lim > e_pos) ? lim - e_pos : 13'd0;
        len  = {e_lenhi, data_byte};

        phase_next = e_phase;
        plane_next = e_plane;
        pos_next   = e_pos;
        lit_next   = e_lit;
        run_next   = e_run;
        lenhi_next = e_lenhi;
        row_next   = e_row;
        halt_next  = e_halt;
        err_next   = err_reg;
        outcome    = OUT_NONE;
        dep        = 1'b0;
        dep_c      = e_run;

        if (!e_halt)
        begin
            case (e_phase)
                PH_MAGIC1:
                begin
                    if (data_byte != MAGIC_BYTE)
                    begin
                        outcome  = OUT_FAIL;
                        err_next = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next = PH_MAGIC2;
                    end
                end
                PH_MAGIC2:
                begin
                    if (data_byte != MAGIC_BYTE)
                    begin
                        outcome  = OUT_FAIL;
                        err_next = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next = PH_LENHI;
                    end
                end
                PH_LENHI:
                begin
                    lenhi_next = data_byte;
                    phase_next = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (width_reg < 13'd8 || width_reg > 13'(MAX_WIDTH)
                        || len != {3'd0, width_reg})
                    begin
                        outcome  = OUT_FAIL;
                        err_next = ST_BAD_LEN;
                    end
                    else
                    begin
                        plane_next = 2'd0;
                        pos_next   = 13'd0;
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (data_byte > RUN_MARK)
                    begin
                        run_next   = 7'(data_byte - RUN_MARK);
                        phase_next = PH_VALUE;
                    end
                    else if (data_byte == 8'd0 || {5'd0, data_byte} > left)
                    begin
                        outcome  = OUT_FAIL;
                        err_next = ST_BAD_COUNT;
                    end
                    else
                    begin
                        lit_next   = data_byte;
                        phase_next = PH_LITERAL;
                    end
                end
                PH_VALUE:
                begin
                    if (e_run == 7'd0 || {6'd0, e_run} > left)
                    begin
                        outcome  = OUT_FAIL;
                        err_next = ST_BAD_COUNT;
                    end
                    else
                    begin
                        dep = 1'b1;
                    end
                end
                PH_LITERAL:
                begin
                    if (e_lit == 8'd0 || left == 13'd0)
                    begin
                        outcome  = OUT_FAIL;
                        err_next = ST_BAD_COUNT;
                    end
                    else
                    begin
                        dep      = 1'b1;
                        dep_c    = 7'd1;
                        lit_next = e_lit - 8'd1;
                    end
                end
                default: outcome = OUT_NONE;
            endcase
        end

        if (outcome == OUT_FAIL)
        begin
            halt_next = 1'b1;
        end

        dep_sum     = {1'b0, e_pos} + {7'd0, dep_c};
        dep_end     = dep_sum >= {1'b0, lim};
        dep_lastrow = ({1'b0, e_row} + 17'd1) >= {1'b0, height_reg};

        if (dep)
        begin
            outcome    = OUT_DEP;
            phase_next = PH_COUNT;
            pos_next   = dep_sum[12:0];
            if (dep_end)
            begin
                pos_next   = 13'd0;
                plane_next = e_plane + 2'd1;
                if (e_plane == PLANE_E)
                begin
                    plane_next = 2'd0;
                    row_next   = e_row + 16'd1;
                    phase_next = dep_lastrow ? PH_IDLE : PH_MAGIC1;
                end
            end
            if (e_phase == PH_LITERAL && lit_next != 8'd0 && phase_next == PH_COUNT)
            begin
                phase_next = PH_LITERAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd8;
            height_reg <= 16'd1;
            phase_reg  <= PH_MAGIC1;
            plane_reg  <= 2'd0;
            pos_reg    <= 13'd0;
            lit_reg    <= 8'd0;
            run_reg    <= 7'd0;
            lenhi_reg  <= 8'd0;
            row_reg    <= 16'd0;
            halt_reg   <= 1'b0;
            err_reg    <= ST_OK;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data[12:0];
            end
            if (cfg_valid && cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                plane_reg <= plane_next;
                pos_reg   <= pos_next;
                lit_reg   <= lit_next;
                run_reg   <= run_next;
                lenhi_reg <= lenhi_next;
                row_reg   <= row_next;
                halt_reg  <= halt_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && dep)
        begin
            rbase_reg  <= e_pos[11:0];
            rcnt_reg   <= dep_c;
            rval_reg   <= data_byte;
            rplane_reg <= e_plane;
            rend_reg   <= dep_end;
            rlast_reg  <= dep_lastrow;
            rrow_reg   <= e_row;
            ridx_reg   <= 7'd0;
        end
        else if (cmd.wr)
        begin
            ridx_reg <= ridx_reg + 7'd1;
        end
        else if (cmd.emit)
        begin
            ridx_reg <= ridx_reg + 7'd2;
        end
        if (cmd.cap_a)
        begin
            pix_a_reg <= {rd_b, rd_g, rd_r};
        end
        if (cmd.cap_b)
        begin
            pix_b_reg <= two ? {rd_b, rd_g, rd_r} : 24'd0;
        end
    end

    assign waddr = rbase_reg + {5'd0, ridx_reg};
    assign raddr = rbase_reg + {5'd0, ridx_reg} + {11'd0, cmd.rd_second};

    rgbe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_r (
        .clk   (clk),
        .we    (cmd.wr && rplane_reg == 2'd0),
        .waddr (waddr),
        .wdata (rval_reg),
        .raddr (raddr),
        .rdata (rd_r)
    );

    rgbe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_g (
        .clk   (clk),
        .we    (cmd.wr && rplane_reg == 2'd1),
        .waddr (waddr),
        .wdata (rval_reg),
        .raddr (raddr),
        .rdata (rd_g)
    );

    rgbe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_b (
        .clk   (clk),
        .we    (cmd.wr && rplane_reg == 2'd2),
        .waddr (waddr),
        .wdata (rval_reg),
        .raddr (raddr),
        .rdata (rd_b)
    );

    assign rem       = {1'b0, rcnt_reg} - {1'b0, ridx_reg};
    assign two       = rem >= 8'd2;
    assign pair_last = rem <= 8'd2;
    assign out_free  = !out_valid_reg || out_ready;
    assign load      = cmd.emit || cmd.err_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_r1_reg   <= to_single(pix_a_reg[7:0], rval_reg);
            o_g1_reg   <= to_single(pix_a_reg[15:8], rval_reg);
            o_b1_reg   <= to_single(pix_a_reg[23:16], rval_reg);
            o_r2_reg   <= two ? to_single(pix_b_reg[7:0], rval_reg) : 32'd0;
            o_g2_reg   <= two ? to_single(pix_b_reg[15:8], rval_reg) : 32'd0;
            o_b2_reg   <= two ? to_single(pix_b_reg[23:16], rval_reg) : 32'd0;
            o_col_reg  <= rbase_reg + {5'd0, ridx_reg};
            o_row_reg  <= rrow_reg;
            o_cnt_reg  <= two ? 2'd2 : 2'd1;
            o_last_reg <= pair_last;
            o_done_reg <= pair_last && rend_reg && rlast_reg;
            o_st_reg   <= ST_OK;
        end
        else if (cmd.err_load)
        begin
            o_r1_reg   <= 32'd0;
            o_g1_reg   <= 32'd0;
            o_b1_reg   <= 32'd0;
            o_r2_reg   <= 32'd0;
            o_g2_reg   <= 32'd0;
            o_b2_reg   <= 32'd0;
            o_col_reg  <= pos_reg[11:0];
            o_row_reg  <= row_reg;
            o_cnt_reg  <= 2'd0;
            o_last_reg <= 1'b1;
            o_done_reg <= 1'b0;
            o_st_reg   <= err_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign first_red    = o_r1_reg;
    assign first_green  = o_g1_reg;
    assign first_blue   = o_b1_reg;
    assign second_red   = o_r2_reg;
    assign second_green = o_g2_reg;
    assign second_blue  = o_b2_reg;
    assign column       = o_col_reg;
    assign scanline     = o_row_reg;
    assign pixel_count  = o_cnt_reg;
    assign last_of_run  = o_last_reg;
    assign image_done   = o_done_reg;
    assign status       = o_st_reg;

    assign stat.outcome   = outcome;
    assign stat.dep_exp   = (e_plane == PLANE_E);
    assign stat.wr_last   = ({1'b0, ridx_reg} + 8'd1) >= {1'b0, rcnt_reg};
    assign stat.pair_last = pair_last;
    assign stat.out_free  = out_free;

    `RGBE_ASSERT_SAME(a_load_when_free, load, out_free)
    `RGBE_ASSERT_NEXT(a_load_shows_valid, load, out_valid_reg)
    `RGBE_ASSERT_SAME(a_write_not_exp, cmd.wr, rplane_reg != PLANE_E)

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the RGBE run-length scanline decoder.
// It drives encoded scanlines, including error cases, and checks every result.
// It depends on rgbe_pkg and rgbe_rle_scanline_decoder_unit.
module testbench;
    import rgbe_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 300;
    localparam int NO_MARK = -1;

    typedef struct {
        logic [31:0] fr, fg, fb, sr, sg, sb;
        logic [11:0] col;
        logic [15:0] row;
        logic [1:0]  cnt;
        logic        last, done;
        logic [1:0]  st;
    } pixel_pair_t;

    typedef struct {
        logic [7:0] b;
        logic       s;
        int         mark;
    } dir_row_t;

    logic clk, rst_n;
    logic in_valid, in_ready, start_image;
    logic [7:0] data_byte;
    logic cfg_valid, cfg_ready;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;
    logic out_valid, out_ready;
    logic [31:0] first_red, first_green, first_blue, second_red, second_green, second_blue;
    logic [11:0] column;
    logic [15:0] scanline;
    logic [1:0]  pixel_count, status;
    logic        last_of_run, image_done;

    rgbe_rle_scanline_decoder_unit dut (.*);

    pixel_pair_t pixel_q[$];
    int          mark_q[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    int          hold_cycles = 0;
    bit          quiet = 0;

    int unsigned w_reg, h_reg, pos, lit_left, run_len, len_hi, rows, plane;
    phase_t      ph;
    bit          halted;
    logic [23:0] rgb_row[MAX_WIDTH];

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [31:0] to_fp32(input logic [7:0] m, input logic [7:0] e);
        logic [8:0]  n;
        logic [31:0] w;
        int          k;
        int          ex;
        if (e == 0)
            return 32'd0;
        n = {m, 1'b1};
        k = 0;
        for (int j = 1; j < 9; j++)
            if (n[j])
                k = j;
        ex = int'(e) - 137 + k;
        w = {23'd0, n};
        if (ex >= -126)
            return {1'b0, 8'(ex + 127), 23'(w << (23 - k))};
        return w << (int'(e) + 12);
    endfunction

    function automatic int unsigned pixels_left();
        int unsigned lim;
        lim = w_reg > MAX_WIDTH ? MAX_WIDTH : w_reg;
        return lim > pos ? lim - pos : 0;
    endfunction

    task automatic push_error(input logic [1:0] code);
        pixel_pair_t r;
        r = '{default: '0};
        r.col = pos[11:0];
        r.row = rows[15:0];
        r.last = 1;
        r.st = code;
        pixel_q.push_back(r);
        halted = 1;
    endtask

    task automatic fill_pixel(input int unsigned p, input logic [7:0] e,
                              output logic [31:0] r, output logic [31:0] g,
                              output logic [31:0] b);
        logic [23:0] rgb;
        rgb = p < MAX_WIDTH ? rgb_row[p] : 24'd0;
        r = to_fp32(rgb[7:0], e);
        g = to_fp32(rgb[15:8], e);
        b = to_fp32(rgb[23:16], e);
    endtask

    task automatic deposit(input logic [7:0] v, input int unsigned c, inout int n);
        pixel_pair_t r;
        int unsigned p0, lim;
        bit          row_end, last_row;
        p0 = pos;
        lim = w_reg > MAX_WIDTH ? MAX_WIDTH : w_reg;
        row_end = p0 + c >= lim;
        last_row = rows + 1 >= h_reg;
        if (plane < 3)
        begin
            for (int unsigned i = 0; i < c; i++)
                if (p0 + i < MAX_WIDTH)
                    rgb_row[p0 + i][plane * 8 +: 8] = v;
        end
        else
        begin
            for (int unsigned i = 0; i < c; i += 2)
            begin
                r = '{default: '0};
                r.cnt = (c - i) >= 2 ? 2'd2 : 2'd1;
                fill_pixel(p0 + i, v, r.fr, r.fg, r.fb);
                if (r.cnt == 2)
                    fill_pixel(p0 + i + 1, v, r.sr, r.sg, r.sb);
                r.col = 12'(p0 + i);
                r.row = rows[15:0];
                r.last = i + r.cnt >= c;
                r.done = r.last && row_end && last_row;
                r.st = ST_OK;
                pixel_q.push_back(r);
                n++;
            end
        end
        pos = p0 + c;
        ph = PH_COUNT;
        if (row_end)
        begin
            pos = 0;
            plane++;
            if (plane >= 4)
            begin
                plane = 0;
                rows = (rows + 1) & 16'hFFFF;
                ph = last_row ? PH_IDLE : PH_MAGIC1;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic s, output int n,
                               output logic [1:0] code);
        n = 0;
        code = ST_OK;
        if (s)
        begin
            halted = 0;
            rows = 0;
            ph = PH_MAGIC1;
            plane = 0;
            pos = 0;
            lit_left = 0;
            run_len = 0;
            len_hi = 0;
        end
        if (halted || ph == PH_IDLE)
            return;
        case (ph)
            PH_MAGIC1, PH_MAGIC2:
            begin
                if (b != MAGIC_BYTE)
                    code = ST_BAD_MAGIC;
                else
                    ph = ph == PH_MAGIC1 ? PH_MAGIC2 : PH_LENHI;
            end
            PH_LENHI:
            begin
                len_hi = b;
                ph = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (w_reg < 8 || w_reg > MAX_WIDTH || ((len_hi << 8) | b) != w_reg)
                    code = ST_BAD_LEN;
                else
                begin
                    plane = 0;
                    pos = 0;
                    ph = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (b > RUN_MARK)
                begin
                    run_len = (b - RUN_MARK) & 8'h7F;
                    ph = PH_VALUE;
                end
                else if (b == 0 || b > pixels_left())
                    code = ST_BAD_COUNT;
                else
                begin
                    lit_left = b;
                    ph = PH_LITERAL;
                end
            end
            PH_VALUE:
            begin
                if (run_len == 0 || run_len > pixels_left())
                    code = ST_BAD_COUNT;
                else
                    deposit(b, run_len, n);
            end
            default:
            begin
                if (lit_left == 0 || pixels_left() == 0)
                    code = ST_BAD_COUNT;
                else
                begin
                    lit_left--;
                    deposit(b, 1, n);
                    if (lit_left != 0 && ph == PH_COUNT)
                        ph = PH_LITERAL;
                end
            end
        endcase
        if (code != ST_OK)
        begin
            push_error(code);
            n = 1;
        end
    endtask

    always @(posedge clk)
    begin
        int          n, mark;
        logic [1:0]  code;
        pixel_pair_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WIDTH)
                    w_reg = cfg_data & 16'h1FFF;
                else
                    h_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, start_image, n, code);
                mark = mark_q.pop_front();
                if (mark != NO_MARK && (n != 1 || code != mark))
                    report($sformatf("byte %0d: expected status %0d", bytes_sent, mark));
            end
            if (out_valid && out_ready)
            begin
                if (pixel_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    e = pixel_q.pop_front();
                    if (first_red !== e.fr || first_green !== e.fg || first_blue !== e.fb)
                        report($sformatf("first pixel %h %h %h, expected %h %h %h",
                            first_red, first_green, first_blue, e.fr, e.fg, e.fb));
                    if (second_red !== e.sr || second_green !== e.sg || second_blue !== e.sb)
                        report($sformatf("second pixel %h %h %h, expected %h %h %h",
                            second_red, second_green, second_blue, e.sr, e.sg, e.sb));
                    if (column !== e.col || scanline !== e.row)
                        report($sformatf("position %0d/%0d, expected %0d/%0d",
                            column, scanline, e.col, e.row));
                    if (pixel_count !== e.cnt || status !== e.st)
                        report($sformatf("count %0d status %0d, expected %0d %0d",
                            pixel_count, status, e.cnt, e.st));
                    if (last_of_run !== e.last || image_done !== e.done)
                        report($sformatf("last %b done %b, expected %b %b",
                            last_of_run, image_done, e.last, e.done));
                end
            end
        end
    end

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 0;
                hold_cycles--;
            end
            else
                out_ready <= quiet || $urandom_range(99) >= 13;
        end
    end

    task automatic send(input logic [7:0] b, input logic s, input int mark);
        if (!quiet && $urandom_range(99) < 13)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        mark_q.push_back(mark);
        in_valid <= 1;
        data_byte <= b;
        start_image <= s;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_header(input logic [15:0] len, input int mark);
        send(MAGIC_BYTE, 1, NO_MARK);
        send(MAGIC_BYTE, 0, NO_MARK);
        send(len[15:8], 0, NO_MARK);
        send(len[7:0], 0, mark);
    endtask

    // Sends rows of well-formed runs and literal groups; a few bytes are corrupted
    // and some images are cut short by the next start.
    task automatic send_image(input int unsigned w, input int unsigned h, input bit runs_only);
        int unsigned left, c, cut;
        bit          s;
        logic [7:0]  b;
        cut = $urandom_range(99) < 10 ? $urandom_range(3, 40) : 0;
        s = 1;
        for (int r = 0; r < h; r++)
        begin
            if (r > 0)
                s = 0;
            send(MAGIC_BYTE, s, NO_MARK);
            send(MAGIC_BYTE, 0, NO_MARK);
            send(8'(w >> 8), 0, NO_MARK);
            send(8'(w), 0, NO_MARK);
            for (int p = 0; p < 4; p++)
            begin
                left = w;
                while (left > 0)
                begin
                    if (cut == 1)
                        return;
                    if (cut > 1)
                        cut--;
                    b = $urandom_range(99) < 2 ? 8'($urandom) : 8'hFF;
                    if (runs_only || $urandom_range(1))
                    begin
                        c = $urandom_range(1, left < 127 ? left : 127);
                        send(b == 8'hFF ? 8'(RUN_MARK + c) : b, 0, NO_MARK);
                        send(8'($urandom), 0, NO_MARK);
                    end
                    else
                    begin
                        c = $urandom_range(1, left < 128 ? left : 128);
                        send(b == 8'hFF ? 8'(c) : b, 0, NO_MARK);
                        repeat (c) send(8'($urandom), 0, NO_MARK);
                    end
                    left -= c;
                end
            end
        end
        if ($urandom_range(3) == 0)
            send(8'($urandom), 0, NO_MARK);
    endtask

    dir_row_t dir_rows[] = '{
        '{8'h03, 1, ST_BAD_MAGIC},
        '{8'h02, 1, NO_MARK}, '{8'h02, 0, NO_MARK}, '{8'h00, 0, NO_MARK},
        '{8'h09, 0, ST_BAD_LEN},
        '{8'h02, 1, NO_MARK}, '{8'h02, 0, NO_MARK}, '{8'h00, 0, NO_MARK},
        '{8'h08, 0, NO_MARK}, '{8'h00, 0, ST_BAD_COUNT},
        '{8'h02, 1, NO_MARK}, '{8'h02, 0, NO_MARK}, '{8'h00, 0, NO_MARK},
        '{8'h08, 0, NO_MARK},
        '{8'h88, 0, NO_MARK}, '{8'hFF, 0, NO_MARK},
        '{8'h88, 0, NO_MARK}, '{8'h00, 0, NO_MARK},
        '{8'h88, 0, NO_MARK}, '{8'h80, 0, NO_MARK},
        '{8'h84, 0, NO_MARK}, '{8'h00, 0, NO_MARK},
        '{8'h83, 0, NO_MARK}, '{8'hFF, 0, NO_MARK},
        '{8'h01, 0, NO_MARK}, '{8'h01, 0, NO_MARK},
        '{8'h55, 0, NO_MARK}
    };

    initial
    begin
        int unsigned wr, hr;
        rst_n = 0;
        in_valid = 0;
        data_byte = 0;
        start_image = 0;
        cfg_valid = 0;
        cfg_index = REG_WIDTH;
        cfg_data = 0;
        w_reg = 8;
        h_reg = 1;
        ph = PH_MAGIC1;
        plane = 0;
        pos = 0;
        lit_left = 0;
        run_len = 0;
        len_hi = 0;
        rows = 0;
        halted = 0;
        foreach (rgb_row[i])
            rgb_row[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].b, dir_rows[i].s, dir_rows[i].mark);
        drain();

        write_reg(REG_WIDTH, 16'hFFFF);
        send_header(16'h1FFF, ST_BAD_LEN);
        drain();
        write_reg(REG_WIDTH, 16'd5000);
        send_header(16'd5000, ST_BAD_LEN);
        drain();
        write_reg(REG_WIDTH, 16'd7);
        send_header(16'd7, ST_BAD_LEN);
        drain();

        write_reg(REG_WIDTH, 16'd16);
        write_reg(REG_HEIGHT, 16'd1);
        hold_cycles = 400;
        send_image(16, 1, 1);
        drain();

        write_reg(REG_WIDTH, 16'd8);
        write_reg(REG_HEIGHT, 16'hFFFF);
        quiet = 1;
        send_image(8, $urandom_range(1, 2), 0);
        quiet = 0;
        drain();

        while (bytes_sent < 170)
        begin
            wr = $urandom_range(8, 12);
            hr = $urandom_range(0, 3);
            write_reg(REG_WIDTH, 16'(wr));
            write_reg(REG_HEIGHT, 16'(hr));
            send_image(wr, hr == 0 ? 1 : hr, 0);
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
